### rtl/mlr_pkg.sv
// Package for the midpoint line rasterizer.
// Holds the operation codes and the line flag group shared by the front, the queue and the back.
// No dependencies.
package mlr_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Per-command flags carried through the command queue
    typedef struct packed {
        logic is_load;
        logic steep;
        logic x_dec;
        logic y_dec;
    } t_line_flags;

    localparam int unsigned FLAGS_W = $bits(t_line_flags);

endpackage

### rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer top level: all-octant line walker, one pixel per step command.
// Depends on mlr_pkg, mlr_front, mlr_queue and mlr_back.
//
// Usage:
//   Slave stream (s_axis): tuser = op (0 load endpoints, 1 step). tdata carries
//   start_x, start_y, end_x, end_y (COORD_BITS each, from bit 0 up, zero padded).
//   A load transaction sets up a new line (dropping any line in progress) and
//   gives no result. Each step transaction gives one pixel while a line is
//   active; a step with no active line gives nothing.
//   Master stream (m_axis): tdata = pixel_x, pixel_y (from bit 0 up, zero
//   padded); tlast is high on the line's final endpoint.
// Timing:
//   Throughput is one transaction per clock on both sides while the receiver
//   does not stall. A step transaction is registered in the command queue and
//   then in the output register before its pixel appears. Each pixel costs one
//   add and compare on the decision term in the back end.
// Reset and stalls:
//   Synchronous active-low reset empties the queue, clears the line state (no
//   line active) and drops any pending result. When the receiver stalls, the
//   result holds in the output register and the queue keeps taking commands
//   until it is full, then s_axis tready drops.
module midpoint_line_rasterizer #(
    parameter int unsigned COORD_BITS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // slave stream
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata: start_x, start_y, end_x, end_y, zero pad
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: op
    input  logic [0:0]                   i_s_axis_tuser,
    // master stream
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // tdata: pixel_x, pixel_y, zero pad
    output logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    output logic                         o_m_axis_tlast
);
    import mlr_pkg::*;

    localparam int unsigned CB      = COORD_BITS;
    localparam int unsigned DW      = CB + 3;
    localparam int unsigned ENTRY_W = FLAGS_W + 2*CB + (CB + 1) + 3*DW;
    localparam int unsigned QDEPTH  = 4;

    // front outputs
    t_line_flags          f_flags;
    logic [CB-1:0]        f_start_x;
    logic [CB-1:0]        f_start_y;
    logic [CB:0]          f_count;
    logic signed [DW-1:0] f_dec;
    logic signed [DW-1:0] f_inc_e;
    logic signed [DW-1:0] f_inc_ne;

    // queue head, unpacked
    t_line_flags          q_flags;
    logic [CB-1:0]        q_start_x;
    logic [CB-1:0]        q_start_y;
    logic [CB:0]          q_count;
    logic signed [DW-1:0] q_dec;
    logic signed [DW-1:0] q_inc_e;
    logic signed [DW-1:0] q_inc_ne;

    logic [ENTRY_W-1:0]   q_wdata;
    logic [ENTRY_W-1:0]   q_rdata;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic                 s_accept;

    logic [CB-1:0]        pix_x;
    logic [CB-1:0]        pix_y;

    assign o_s_axis_tready = !q_full;
    assign s_accept        = i_s_axis_tvalid && !q_full;

    mlr_front #(
        .COORD_BITS(CB)
    ) u_front (
        .i_op      (i_s_axis_tuser[0]),
        .i_start_x (i_s_axis_tdata[CB-1:0]),
        .i_start_y (i_s_axis_tdata[2*CB-1:CB]),
        .i_end_x   (i_s_axis_tdata[3*CB-1:2*CB]),
        .i_end_y   (i_s_axis_tdata[4*CB-1:3*CB]),
        .o_flags   (f_flags),
        .o_start_x (f_start_x),
        .o_start_y (f_start_y),
        .o_count   (f_count),
        .o_dec     (f_dec),
        .o_inc_e   (f_inc_e),
        .o_inc_ne  (f_inc_ne)
    );

    assign q_wdata = {f_flags, f_start_x, f_start_y, f_count, f_dec, f_inc_e, f_inc_ne};

    mlr_queue #(
        .WIDTH(ENTRY_W),
        .DEPTH(QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_accept),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {q_flags, q_start_x, q_start_y, q_count, q_dec, q_inc_e, q_inc_ne} = q_rdata;

    mlr_back #(
        .COORD_BITS(CB)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_flags     (q_flags),
        .i_start_x   (q_start_x),
        .i_start_y   (q_start_y),
        .i_count     (q_count),
        .i_dec       (q_dec),
        .i_inc_e     (q_inc_e),
        .i_inc_ne    (q_inc_ne),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_pixel_x   (pix_x),
        .o_pixel_y   (pix_y),
        .o_last      (o_m_axis_tlast)
    );

    // pixel fields from bit 0 up, pad bits tied low
    always_comb begin
        o_m_axis_tdata           = '0;
        o_m_axis_tdata[CB-1:0]   = pix_x;
        o_m_axis_tdata[2*CB-1:CB] = pix_y;
    end

endmodule

### rtl/mlr_front.sv
// Front end of the midpoint line rasterizer: classifies items and sets up a line on load.
// Depends on mlr_pkg.
module mlr_front #(
    parameter int unsigned COORD_BITS = 10
) (
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output mlr_pkg::t_line_flags  o_flags,
    output logic [COORD_BITS-1:0] o_start_x,
    output logic [COORD_BITS-1:0] o_start_y,
    output logic [COORD_BITS:0]   o_count,
    output logic signed [COORD_BITS+2:0] o_dec,
    output logic signed [COORD_BITS+2:0] o_inc_e,
    output logic signed [COORD_BITS+2:0] o_inc_ne
);
    import mlr_pkg::*;

    localparam int unsigned DW = COORD_BITS + 3;

    logic                  x_dec;
    logic                  y_dec;
    logic                  steep;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic signed [DW-1:0]  major_s;
    logic signed [DW-1:0]  minor_s;

    always_comb begin
        x_dec   = i_end_x < i_start_x;
        y_dec   = i_end_y < i_start_y;
        dx      = x_dec ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
        dy      = y_dec ? (i_start_y - i_end_y) : (i_end_y - i_start_y);
        steep   = dy > dx;               // tie keeps x as the major axis
        major   = steep ? dy : dx;
        minor   = steep ? dx : dy;
        major_s = signed'(DW'(major));
        minor_s = signed'(DW'(minor));

        o_flags.is_load = (i_op == OP_LOAD);
        o_flags.steep   = steep;
        o_flags.x_dec   = x_dec;
        o_flags.y_dec   = y_dec;
        o_start_x       = i_start_x;
        o_start_y       = i_start_y;
        o_count         = (COORD_BITS+1)'(major) + (COORD_BITS+1)'(1);
        o_dec           = (minor_s <<< 1) - major_s;
        o_inc_e         = minor_s <<< 1;
        o_inc_ne        = (minor_s - major_s) <<< 1;
    end

endmodule

### rtl/mlr_queue.sv
// Command queue between front and back of the midpoint line rasterizer.
// Small register FIFO with first-word-fall-through read. No package dependency.
module mlr_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? f_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? f_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

### rtl/mlr_back.sv
// Back end of the midpoint line rasterizer: walks the active line one pixel per step command.
// Depends on mlr_pkg; holds the line state and the output register.
module mlr_back #(
    parameter int unsigned COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_pop,
    input  mlr_pkg::t_line_flags  i_flags,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS:0]   i_count,
    input  logic signed [COORD_BITS+2:0] i_dec,
    input  logic signed [COORD_BITS+2:0] i_inc_e,
    input  logic signed [COORD_BITS+2:0] i_inc_ne,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last
);
    import mlr_pkg::*;

    localparam int unsigned DW = COORD_BITS + 3;
    localparam int unsigned NW = COORD_BITS + 1;

    // line state
    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic signed [DW-1:0]  r_dec, n_dec;
    logic signed [DW-1:0]  r_inc_e, n_inc_e;
    logic signed [DW-1:0]  r_inc_ne, n_inc_ne;
    logic                  r_steep, n_steep;
    logic                  r_x_dec, n_x_dec;
    logic                  r_y_dec, n_y_dec;
    logic [NW-1:0]         r_left, n_left;
    logic                  r_active, n_active;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;
    logic                  r_out_last, n_out_last;

    logic pop;
    logic emit;
    logic step_minor;

    always_comb begin
        pop  = i_cmd_valid && (!r_out_valid || i_ready);
        emit = pop && !i_flags.is_load && r_active;
        step_minor = (r_dec > 0);

        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_dec    = r_dec;
        n_inc_e  = r_inc_e;
        n_inc_ne = r_inc_ne;
        n_steep  = r_steep;
        n_x_dec  = r_x_dec;
        n_y_dec  = r_y_dec;
        n_left   = r_left;
        n_active = r_active;

        n_out_valid = r_out_valid && !i_ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;

        if (pop && i_flags.is_load) begin
            n_cur_x  = i_start_x;
            n_cur_y  = i_start_y;
            n_dec    = i_dec;
            n_inc_e  = i_inc_e;
            n_inc_ne = i_inc_ne;
            n_steep  = i_flags.steep;
            n_x_dec  = i_flags.x_dec;
            n_y_dec  = i_flags.y_dec;
            n_left   = i_count;
            n_active = 1'b1;
        end else if (emit) begin
            n_out_valid = 1'b1;
            n_out_x     = r_cur_x;
            n_out_y     = r_cur_y;
            n_out_last  = (r_left == NW'(1));
            if (r_left <= NW'(1)) begin
                // final endpoint: cursor holds, line retires
                n_left   = '0;
                n_active = 1'b0;
            end else begin
                n_left = r_left - NW'(1);
                if (step_minor) begin
                    n_dec = r_dec + r_inc_ne;
                end else begin
                    n_dec = r_dec + r_inc_e;
                end
                if (r_steep || step_minor) begin
                    n_cur_y = r_y_dec ? (r_cur_y - COORD_BITS'(1))
                                      : (r_cur_y + COORD_BITS'(1));
                end
                if (!r_steep || step_minor) begin
                    n_cur_x = r_x_dec ? (r_cur_x - COORD_BITS'(1))
                                      : (r_cur_x + COORD_BITS'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_dec       <= '0;
            r_inc_e     <= '0;
            r_inc_ne    <= '0;
            r_steep     <= 1'b0;
            r_x_dec     <= 1'b0;
            r_y_dec     <= 1'b0;
            r_left      <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_dec       <= n_dec;
            r_inc_e     <= n_inc_e;
            r_inc_ne    <= n_inc_ne;
            r_steep     <= n_steep;
            r_x_dec     <= n_x_dec;
            r_y_dec     <= n_y_dec;
            r_left      <= n_left;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

    assign o_cmd_pop = pop;
    assign o_valid   = r_out_valid;
    assign o_pixel_x = r_out_x;
    assign o_pixel_y = r_out_y;
    assign o_last    = r_out_last;

endmodule
